FILE: hw/rtl/chte_pkg.sv
package chte_pkg;

  // Field widths fixed by the item format
  localparam int KEY_W  = 31;
  localparam int ROOM_W = 16;
  localparam int HDL_W  = 16;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       clr_wr;
    logic       load_item;
    logic       head_take;
    logic       walk_next;
    logic       hit_take;
    logic       free_rd;
    logic       alloc;
    logic       del_unlink;
    logic       del_free;
    logic       load_out;
    logic       res_found;
    logic [1:0] res_status;
  } chte_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       clr_last;
    logic       hash_done;
    logic       cur_ok;
    logic       key_match;
    logic       free_avail;
    logic       fresh_avail;
    logic       out_free;
    logic [1:0] op;
  } chte_sts_t;

endpackage

FILE: hw/rtl/chte_ctrl.sv
module chte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  chte_pkg::chte_sts_t sts,
  output chte_pkg::chte_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_CMP,
    S_FREE_RD,
    S_ALLOC,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_DONE
  } state_t;

  state_t     state;
  logic [1:0] res_status;
  logic       res_found;

  assign in_stall = (state != S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.res_status = res_status;
    cmd.res_found  = res_found;
    unique case (state)
      S_CLEAR:      cmd.clr_wr     = 1'b1;
      S_IDLE:       cmd.load_item  = in_valid;
      S_HEAD:       cmd.head_take  = 1'b1;
      S_CMP: begin
        cmd.walk_next = sts.cur_ok && !sts.key_match;
        cmd.hit_take  = sts.key_match;
      end
      S_FREE_RD:    cmd.free_rd    = 1'b1;
      S_ALLOC:      cmd.alloc      = 1'b1;
      S_DEL_UNLINK: cmd.del_unlink = 1'b1;
      S_DEL_FREE:   cmd.del_free   = 1'b1;
      S_DONE:       cmd.load_out   = sts.out_free;
      default:      cmd.load_out   = 1'b0;
    endcase
  end

  // Sequence one item: hash, fetch head, walk the chain, act, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      res_status <= chte_pkg::STATUS_NOT_FOUND;
      res_found  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            res_found <= 1'b0;
            state     <= S_HASH;
          end
        end
        S_HASH: if (sts.hash_done) state <= S_HEAD;
        S_HEAD: state <= S_CMP;
        S_CMP: begin
          if (sts.key_match) begin
            priority case (sts.op)
              chte_pkg::OP_INSERT: begin
                res_status <= chte_pkg::STATUS_DUPLICATE;
                state      <= S_DONE;
              end
              chte_pkg::OP_LOOKUP: begin
                res_status <= chte_pkg::STATUS_OK;
                res_found  <= 1'b1;
                state      <= S_DONE;
              end
              chte_pkg::OP_DELETE: state <= S_DEL_UNLINK;
              default: begin
                res_status <= chte_pkg::STATUS_NOT_FOUND;
                state      <= S_DONE;
              end
            endcase
          end else if (!sts.cur_ok) begin
            if (sts.op == chte_pkg::OP_INSERT) begin
              priority if (sts.free_avail) begin
                state <= S_FREE_RD;
              end else if (sts.fresh_avail) begin
                state <= S_ALLOC;
              end else begin
                res_status <= chte_pkg::STATUS_POOL_FULL;
                state      <= S_DONE;
              end
            end else begin
              res_status <= chte_pkg::STATUS_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_FREE_RD: state <= S_ALLOC;
        S_ALLOC: begin
          res_status <= chte_pkg::STATUS_OK;
          state      <= S_DONE;
        end
        S_DEL_UNLINK: state <= S_DEL_FREE;
        S_DEL_FREE: begin
          res_status <= chte_pkg::STATUS_OK;
          state      <= S_DONE;
        end
        S_DONE: if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/chte_datapath.sv
module chte_datapath #(
  parameter int BUCKET_COUNT = 16,
  parameter int POOL_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  chte_pkg::chte_cmd_t               cmd,
  output chte_pkg::chte_sts_t               sts,
  input  logic [1:0]                        operation,
  input  logic [chte_pkg::KEY_W-1:0]        key,
  input  logic [chte_pkg::ROOM_W-1:0]       room,
  input  logic [chte_pkg::HDL_W-1:0]        record_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [chte_pkg::ROOM_W-1:0]       found_room,
  output logic [chte_pkg::HDL_W-1:0]        found_handle
);

  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int KW = chte_pkg::KEY_W;
  localparam int RW = chte_pkg::ROOM_W;
  localparam int HW = chte_pkg::HDL_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);
  localparam logic [BW-1:0] CLR_LAST  = BW'(BUCKET_COUNT - 1);
  localparam bit IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

  typedef struct packed {
    logic [KW-1:0] key;
    logic [RW-1:0] room;
    logic [HW-1:0] hdl;
  } entry_t;

  // Storage
  logic [LW-1:0] heads_mem [BUCKET_COUNT];
  entry_t        kv_mem    [POOL_ENTRIES];
  logic [LW-1:0] link_mem  [POOL_ENTRIES];

  // Item and walk registers
  logic [1:0]    op_r;
  logic [KW-1:0] key_r;
  logic [RW-1:0] room_r;
  logic [HW-1:0] hdl_r;
  logic [BW-1:0] bucket;
  logic          hash_done;
  logic [LW-1:0] cur, prev, steps, head_val, hit, hit_link;
  logic [RW-1:0] fr;
  logic [HW-1:0] fh;
  logic [LW-1:0] free_head, fresh_cnt;
  logic [BW-1:0] clr_idx;

  // Registered read data
  logic [LW-1:0] head_q, link_q;
  entry_t        kv_q;

  // Write port controls
  logic          head_we, link_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd, link_wd, slot;
  logic [AW-1:0] link_wa, rd_addr;
  logic          cur_ok, free_avail, fresh_avail;

  // Bucket index: mask for a power of two, else a registered reciprocal multiply
  if (IS_POW2) begin : g_mask
    assign bucket    = key_r[BW-1:0] & BW'(BUCKET_COUNT - 1);
    assign hash_done = 1'b1;
  end else begin : g_rem
    localparam int SH = KW + $clog2(BUCKET_COUNT);
    localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
    logic [KW+31:0] prod_q;
    logic [KW-1:0]  quo;
    logic [BW-1:0]  rem;
    logic [1:0]     hcnt;
    assign quo       = KW'(prod_q >> SH);
    assign bucket    = rem;
    assign hash_done = (hcnt == 2'd0);
    always_ff @(posedge clk) begin
      if (rst) begin
        hcnt <= '0;
      end else if (cmd.load_item) begin
        hcnt <= 2'd2;
      end else if (hcnt != 2'd0) begin
        hcnt <= hcnt - 2'd1;
      end
      // Quotient estimate first, then the remainder from it
      if (hcnt == 2'd2) begin
        prod_q <= (KW+32)'(key_r) * (KW+32)'(RECIP[31:0]);
      end
      if (hcnt == 2'd1) begin
        rem <= BW'(key_r - (quo * KW'(BUCKET_COUNT)));
      end
    end
  end

  assign cur_ok      = (cur < NULL_LINK) && (steps < NULL_LINK);
  assign free_avail  = (free_head < NULL_LINK);
  assign fresh_avail = (fresh_cnt < NULL_LINK);
  assign slot        = free_avail ? free_head : fresh_cnt;

  always_comb begin
    sts.clr_last    = (clr_idx == CLR_LAST);
    sts.hash_done   = hash_done;
    sts.cur_ok      = cur_ok;
    sts.key_match   = cur_ok && (kv_q.key == key_r);
    sts.free_avail  = free_avail;
    sts.fresh_avail = fresh_avail;
    sts.out_free    = !out_valid || !out_stall;
    sts.op          = op_r;
  end

  // Select the entry read address
  always_comb begin
    priority if (cmd.head_take) rd_addr = head_q[AW-1:0];
    else if (cmd.walk_next)     rd_addr = link_q[AW-1:0];
    else if (cmd.free_rd)       rd_addr = free_head[AW-1:0];
    else                        rd_addr = cur[AW-1:0];
  end

  // Steer the head and link write ports
  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = slot;
    link_we = 1'b0;
    link_wa = slot[AW-1:0];
    link_wd = head_val;
    priority if (cmd.clr_wr) begin
      head_we = 1'b1;
      head_wa = clr_idx;
      head_wd = NULL_LINK;
    end else if (cmd.alloc) begin
      head_we = 1'b1;
      link_we = 1'b1;
    end else if (cmd.del_unlink) begin
      head_we = (prev == NULL_LINK);
      head_wd = hit_link;
      link_we = (prev != NULL_LINK);
      link_wa = prev[AW-1:0];
      link_wd = hit_link;
    end else if (cmd.del_free) begin
      link_we = 1'b1;
      link_wa = hit[AW-1:0];
      link_wd = free_head;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (head_we) heads_mem[head_wa] <= head_wd;
    head_q <= heads_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) kv_mem[slot[AW-1:0]] <= '{key: key_r, room: room_r, hdl: hdl_r};
    kv_q <= kv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q <= link_mem[rd_addr];
  end

  // Item capture and chain walk
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= operation;
      key_r  <= key;
      room_r <= room;
      hdl_r  <= record_handle;
    end
    if (cmd.head_take) begin
      cur      <= head_q;
      head_val <= head_q;
      prev     <= NULL_LINK;
      steps    <= '0;
    end else if (cmd.walk_next) begin
      prev  <= cur;
      cur   <= link_q;
      steps <= steps + 1'b1;
    end
    if (cmd.hit_take) begin
      hit      <= cur;
      hit_link <= link_q;
      fr       <= kv_q.room;
      fh       <= kv_q.hdl;
    end
  end

  // Pool bookkeeping and the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= NULL_LINK;
      fresh_cnt <= '0;
      clr_idx   <= '0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + 1'b1;
      if (cmd.alloc) begin
        if (free_avail) free_head <= link_q;
        else            fresh_cnt <= fresh_cnt + 1'b1;
      end
      if (cmd.del_free) free_head <= hit;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= cmd.res_status;
      found_room   <= cmd.res_found ? fr : '0;
      found_handle <= cmd.res_found ? fh : '0;
    end
  end

endmodule

FILE: hw/rtl/chained_hash_table_engine_core.sv
// Chained hash table: insert, lookup and delete of keyed entries.
// Input channel (in_valid/in_stall) carries operation, key, room and
// record_handle; a transfer happens when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall) carries status, found_room and
// found_handle, one result per input item, in order.
// After reset the bucket heads are swept to empty, one bucket per cycle;
// in_stall stays high during the sweep.
// One item is processed at a time, one entry memory read per chain link.
// After the transfer the key is hashed (a mask for a power-of-two
// BUCKET_COUNT, a registered remainder unit otherwise), the bucket head
// is read and the chain is walked; an insert then allocates an entry and
// a delete unlinks and frees the entry before the result is loaded.
// A new item is taken in the cycle after the result is loaded.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls, the result holds and the block stalls
// its input once the next result is ready.
module chained_hash_table_engine_core #(
  parameter int BUCKET_COUNT = 16,
  parameter int POOL_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [chte_pkg::KEY_W-1:0]  key,
  input  logic [chte_pkg::ROOM_W-1:0] room,
  input  logic [chte_pkg::HDL_W-1:0]  record_handle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [chte_pkg::ROOM_W-1:0] found_room,
  output logic [chte_pkg::HDL_W-1:0]  found_handle
);

  chte_pkg::chte_cmd_t cmd;
  chte_pkg::chte_sts_t sts;

  chte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  chte_datapath #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .key           (key),
    .room          (room),
    .record_handle (record_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found_room    (found_room),
    .found_handle  (found_handle)
  );

endmodule

FILE: hw/rtl/chte_checker.sv
module chte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] found_room,
  input logic [15:0] found_handle
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(found_room) && $stable(found_handle))
    else $error("stalled result changed");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Found fields are zero unless the status is success
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != chte_pkg::STATUS_OK |->
      found_room == '0 && found_handle == '0)
    else $error("found fields nonzero on failure");

  // One item at a time: input stalls right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind chained_hash_table_engine_core chte_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .found_room   (found_room),
  .found_handle (found_handle)
);
